// ===== src/boundary_flood_sweep_3d_defines.svh =====
// Assertion macros for the boundary flood sweep block.
// Used by boundary_flood_sweep_3d.sv; expects clk and arst_n in scope.
`ifndef BOUNDARY_FLOOD_SWEEP_3D_DEFINES_SVH
`define BOUNDARY_FLOOD_SWEEP_3D_DEFINES_SVH

// condition must hold at every edge out of reset
`define BFS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger at one edge implies condition at the next
`define BFS_ASSERT_NEXT(lbl, trig, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== src/bfs3d_pkg.sv =====
// Package for the boundary flood sweep: register codes, beat type, float helpers.
// No dependencies.
`timescale 1ns / 1ps

package bfs3d_pkg;

	typedef enum logic [1:0] {
		REG_X_SIZE    = 2'd0,
		REG_Y_SIZE    = 2'd1,
		REG_Z_SIZE    = 2'd2,
		REG_HALF_FILL = 2'd3
	} cfg_reg_t;

	localparam int unsigned INDEX_W = 18;
	localparam int unsigned VOXEL_W = 32;

	typedef struct packed {
		logic               last;
		logic [VOXEL_W-1:0] bits;
		logic [INDEX_W-1:0] index;
	} out_beat_t;

	// +0 and -0
	function automatic logic f_is_zero(input logic [VOXEL_W-1:0] b);
		return b[30:0] == 31'd0;
	endfunction

	function automatic logic f_is_nan(input logic [VOXEL_W-1:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// float equality on bit patterns
	function automatic logic f_equal(input logic [VOXEL_W-1:0] a, input logic [VOXEL_W-1:0] b);
		logic nan_any;
		nan_any = f_is_nan(a) || f_is_nan(b);
		return !nan_any && ((f_is_zero(a) && f_is_zero(b)) || (a == b));
	endfunction

endpackage

// ===== src/boundary_flood_sweep_3d.sv =====
// Boundary flood sweep over a raster-order 3D voxel stream, one plane of delay.
// Depends on bfs3d_pkg and boundary_flood_sweep_3d_defines.svh.
`timescale 1ns / 1ps
`include "boundary_flood_sweep_3d_defines.svh"

// Channel  | dir | beat
// s_*      | in  | tdata = voxel_bits[31:0]; tuser = opcode (1 = flush)
// m_*      | out | tdata = voxel_index[17:0], result_bits[49:18], zero pad; tlast = last_voxel
// cfg_*    | in  | cfg_addr selects x_size, y_size, z_size, half_fill; cfg_wdata
//
// One beat per cycle sustained; a beat that completes a neighborhood (or a drain
// flush) yields one output beat, registered in the decide stage and then queued.
// Rate set by the single read pass over the raw plane buffer and zero-flag buffer.
// Reset clears counters and the output queue; the buffers are not cleared.
// s_tready drops when the three-entry output queue could overflow, and after
// reset or a size write until the plane/total products settle.

module boundary_flood_sweep_3d #(
	parameter int unsigned MAX_X = 64,
	parameter int unsigned MAX_Y = 64,
	parameter int unsigned MAX_Z = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] voxel_bits
	input  logic        s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [17:0] voxel_index, [49:18] result_bits, [55:50] zero
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	localparam longint unsigned PLANE_MAX = longint'(MAX_X) * longint'(MAX_Y);
	localparam longint unsigned TOTAL_MAX = PLANE_MAX * longint'(MAX_Z);
	localparam int unsigned XW = $clog2(MAX_X + 1);
	localparam int unsigned YW = $clog2(MAX_Y + 1);
	localparam int unsigned ZW = $clog2(MAX_Z + 1);
	localparam int unsigned PW = $clog2(PLANE_MAX + 1);
	localparam int unsigned AW = $clog2(PLANE_MAX);
	localparam int unsigned CW = $clog2(TOTAL_MAX + 1);
	localparam int unsigned FIFO_DEPTH = 3;

	// ---------------- configuration ----------------
	logic [6:0]  x_size_q, y_size_q, z_size_q;
	logic [31:0] half_fill_q;
	logic        size_wr;
	logic [1:0]  cfg_wait_q;   // nonzero until plane/total are valid

	assign size_wr = cfg_we && (bfs3d_pkg::cfg_reg_t'(cfg_addr) != bfs3d_pkg::REG_HALF_FILL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q    <= 7'd64;
			y_size_q    <= 7'd64;
			z_size_q    <= 7'd64;
			half_fill_q <= '0;
		end else if (cfg_we) begin
			case (bfs3d_pkg::cfg_reg_t'(cfg_addr))
				bfs3d_pkg::REG_X_SIZE:    x_size_q    <= cfg_wdata[6:0];
				bfs3d_pkg::REG_Y_SIZE:    y_size_q    <= cfg_wdata[6:0];
				bfs3d_pkg::REG_Z_SIZE:    z_size_q    <= cfg_wdata[6:0];
				bfs3d_pkg::REG_HALF_FILL: half_fill_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wait_q <= 2'd2;
		end else if (size_wr) begin
			cfg_wait_q <= 2'd2;
		end else if (cfg_wait_q != 2'd0) begin
			cfg_wait_q <= cfg_wait_q - 2'd1;
		end
	end

	// clamp each size to [3, MAX]
	logic [31:0] nx_w, ny_w, nz_w;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [ZW-1:0] nz;

	always_comb begin
		nx_w = (x_size_q < 7'd3) ? 32'd3 : ((32'(x_size_q) > MAX_X) ? MAX_X : 32'(x_size_q));
		ny_w = (y_size_q < 7'd3) ? 32'd3 : ((32'(y_size_q) > MAX_Y) ? MAX_Y : 32'(y_size_q));
		nz_w = (z_size_q < 7'd3) ? 32'd3 : ((32'(z_size_q) > MAX_Z) ? MAX_Z : 32'(z_size_q));
		nx = XW'(nx_w);
		ny = YW'(ny_w);
		nz = ZW'(nz_w);
	end

	// products registered one after the other
	logic [PW-1:0] plane_q;
	logic [CW-1:0] total_q;

	always_ff @(posedge clk) begin
		plane_q <= PW'(nx) * PW'(ny);
		total_q <= CW'(plane_q) * CW'(nz);
	end

	// ---------------- counters and stage 0 ----------------
	logic [CW-1:0] rcv_q, ev_q;
	logic [AW-1:0] wptr_q, sv_q;
	logic [XW-1:0] i_q;
	logic [YW-1:0] j_q;
	logic [ZW-1:0] k_q;

	logic acc, vox_ok, emit, last_now, bnd_now;
	logic [1:0] cnt_q;
	logic       s1_valid;
	logic [2:0] busy;

	assign busy     = 3'(cnt_q) + 3'(s1_valid);
	assign s_tready = (busy <= 3'd2) && (cfg_wait_q == 2'd0);
	assign acc      = s_tvalid && s_tready;
	assign vox_ok   = acc && !s_tuser && (rcv_q < total_q);
	assign emit     = (vox_ok && (rcv_q >= CW'(plane_q)))
		|| (acc && s_tuser && (rcv_q >= total_q) && (ev_q < total_q));
	assign last_now = ev_q == (total_q - CW'(1));
	assign bnd_now  = (i_q == '0) || (j_q == '0) || (k_q == '0)
		|| (i_q == nx - XW'(1)) || (j_q == ny - YW'(1)) || (k_q == nz - ZW'(1));

	// neighbor slots in the plane-circular buffers
	logic [PW:0]   sv_ext, nx_ext, pl_ext, sum1, sum2;
	logic [AW-1:0] ra_next, ra_row_ahead, rb_row_back, wptr_nxt, sv_nxt;

	always_comb begin
		sv_ext = (PW+1)'(sv_q);
		nx_ext = (PW+1)'(nx);
		pl_ext = (PW+1)'(plane_q);
		sum1   = sv_ext + (PW+1)'(1);
		sum2   = sv_ext + nx_ext;
		ra_next      = AW'((sum1 >= pl_ext) ? sum1 - pl_ext : sum1);
		ra_row_ahead = AW'((sum2 >= pl_ext) ? sum2 - pl_ext : sum2);
		rb_row_back  = AW'((sv_ext >= nx_ext) ? sv_ext - nx_ext : sv_ext + pl_ext - nx_ext);
		wptr_nxt = ((PW+1)'(wptr_q) + (PW+1)'(1) >= pl_ext) ? '0 : wptr_q + AW'(1);
		sv_nxt   = ra_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q  <= '0;
			ev_q   <= '0;
			wptr_q <= '0;
			sv_q   <= '0;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
		end else if (size_wr || (emit && last_now)) begin
			// drop the volume, or finish it
			rcv_q  <= '0;
			ev_q   <= '0;
			wptr_q <= '0;
			sv_q   <= '0;
			i_q    <= '0;
			j_q    <= '0;
			k_q    <= '0;
		end else begin
			if (vox_ok) begin
				rcv_q  <= rcv_q + CW'(1);
				wptr_q <= wptr_nxt;
			end
			if (emit) begin
				ev_q <= ev_q + CW'(1);
				sv_q <= sv_nxt;
				if (i_q == nx - XW'(1)) begin
					i_q <= '0;
					if (j_q == ny - YW'(1)) begin
						j_q <= '0;
						k_q <= k_q + ZW'(1);
					end else begin
						j_q <= j_q + YW'(1);
					end
				end else begin
					i_q <= i_q + XW'(1);
				end
			end
		end
	end

	// ---------------- memories ----------------
	// raw plane buffer: read v+1 and v+x_size while v+plane lands on slot v
	logic [31:0] raw_mem [PLANE_MAX];
	logic [31:0] a_next_rd, a_row_rd;
	// updated zero flags: read slot v (one plane back) and v-x_size
	logic        zf_mem [PLANE_MAX];
	logic        b_plane_rd, b_row_rd;
	logic        zf_we;
	logic [AW-1:0] sv_s1;
	logic        res_zero;

	always_ff @(posedge clk) begin
		if (vox_ok) begin
			raw_mem[wptr_q] <= s_tdata;
		end
		if (emit) begin
			a_next_rd <= raw_mem[ra_next];
			a_row_rd  <= raw_mem[ra_row_ahead];
		end
	end

	always_ff @(posedge clk) begin
		if (zf_we) begin
			zf_mem[sv_s1] <= res_zero;
		end
		if (emit) begin
			b_plane_rd <= zf_mem[sv_q];
			b_row_rd   <= zf_mem[rb_row_back];
		end
	end

	// ---------------- stage 1: decide ----------------
	logic [CW-1:0] idx_s1;
	logic          bnd_s1, last_s1, inz_s1;
	logic [31:0]   raw_v_q;      // raw value of the voxel being decided
	logic          prev_zero_q;  // updated zero flag of the voxel before it
	logic [31:0]   res_bits;
	logic          keep, nb_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else begin
			s1_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			idx_s1  <= ev_q;
			bnd_s1  <= bnd_now;
			last_s1 <= last_now;
			inz_s1  <= bfs3d_pkg::f_is_zero(s_tdata);
			sv_s1   <= sv_q;
		end
		if (s1_valid) begin
			raw_v_q     <= a_next_rd;
			prev_zero_q <= res_zero;
		end
	end

	always_comb begin
		keep = bfs3d_pkg::f_is_zero(raw_v_q) || bfs3d_pkg::f_equal(raw_v_q, half_fill_q);
		nb_zero = prev_zero_q || bfs3d_pkg::f_is_zero(a_next_rd)
			|| bfs3d_pkg::f_is_zero(a_row_rd) || b_plane_rd || b_row_rd || inz_s1;
		if (bnd_s1) begin
			res_bits = '0;
		end else if (keep) begin
			res_bits = raw_v_q;
		end else if (nb_zero) begin
			res_bits = '0;
		end else begin
			res_bits = raw_v_q;
		end
		res_zero = bfs3d_pkg::f_is_zero(res_bits);
	end

	assign zf_we = s1_valid;

	// ---------------- output queue ----------------
	bfs3d_pkg::out_beat_t fifo_q [FIFO_DEPTH];
	bfs3d_pkg::out_beat_t head;
	logic [1:0] wr_q, rd_q;
	logic       pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = cnt_q != 2'd0;
	assign head     = fifo_q[rd_q];
	assign m_tdata  = {6'd0, head.bits, head.index};
	assign m_tlast  = head.last;

	always_ff @(posedge clk) begin
		if (s1_valid) begin
			fifo_q[wr_q] <= '{last: last_s1, bits: res_bits, index: bfs3d_pkg::INDEX_W'(idx_s1)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (s1_valid) begin
				wr_q <= (wr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= (rd_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
			end
			cnt_q <= cnt_q + 2'(s1_valid) - 2'(pop);
		end
	end

	// ---------------- assertions ----------------
	`BFS_ASSERT_ALWAYS(a_queue_room, !s1_valid || (cnt_q != 2'd3), "output queue overflow")
	`BFS_ASSERT_NEXT(a_emit_stage, emit, s1_valid, "emission lost before decide stage")
	`BFS_ASSERT_NEXT(a_volume_wrap, emit && last_now, (rcv_q == '0) && (ev_q == '0), "counters not cleared")

endmodule
